/* src/csr_graph_random_walk_assert.svh */
// assertion macros shared by the random walk rtl
// needs clk and arst_n in the scope that uses them
`ifndef CSR_GRAPH_RANDOM_WALK_ASSERT_SVH
`define CSR_GRAPH_RANDOM_WALK_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define CSRW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// when pre holds, post must hold at the following clock edge
`define CSRW_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

/* src/csrw_pkg.sv */
// shared types and constants of the csr graph random walk block
// no dependencies
`default_nettype none

package csrw_pkg;

	// request modes
	localparam logic [1:0] MODE_LOAD_OFFS = 2'd0;
	localparam logic [1:0] MODE_LOAD_NBR  = 2'd1;
	localparam logic [1:0] MODE_START     = 2'd2;
	localparam logic [1:0] MODE_STEP      = 2'd3;

	// edge code for start position and for a walker that stays
	localparam logic [12:0] EDGE_NONE = 13'h1FFF;

	// commands from controller to datapath
	typedef struct packed {
		logic wr_offs;
		logic wr_nbr;
		logic start_walk;
		logic rd_offs;
		logic calc;
		logic rd_nbr;
		logic upd;
		logic load_out;
	} csrw_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic active;
		logic out_free;
	} csrw_sts_t;

endpackage

`default_nettype wire

/* src/csrw_if.sv */
// request, result and configuration channels of the random walk block
// no dependencies
`default_nettype none

// request channel
interface csrw_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [12:0] table_index;
	logic [12:0] table_value;
	logic [9:0]  start_node;
	logic [15:0] random_fraction;

	modport source (output valid, mode, table_index, table_value, start_node,
		random_fraction, input ready);
	modport sink (input valid, mode, table_index, table_value, start_node,
		random_fraction, output ready);
endinterface

// result channel
interface csrw_out_if;
	logic              valid;
	logic              ready;
	logic [9:0]        node;
	logic signed [12:0] edge_res;
	logic [7:0]        position;
	logic              last_of_walk;

	modport source (output valid, node, edge_res, position, last_of_walk,
		input ready);
	modport sink (input valid, node, edge_res, position, last_of_walk,
		output ready);
endinterface

// walk length register write channel
interface csrw_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] max_steps;

	modport source (output valid, max_steps, input ready);
	modport sink (input valid, max_steps, output ready);
endinterface

`default_nettype wire

/* src/csrw_ctrl.sv */
// controller state machine of the random walk block
// depends on csrw_pkg and csr_graph_random_walk_assert.svh
`default_nettype none
`include "csr_graph_random_walk_assert.svh"

module csrw_ctrl
	import csrw_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	input  wire logic [1:0] item_mode,
	output logic            item_ready,
	input  wire csrw_sts_t  sts,
	output csrw_cmd_t       cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_NRD  = 3'd2;
	localparam logic [2:0] S_UPD  = 3'd3;
	localparam logic [2:0] S_RES  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       acc;

	assign item_ready = (state_q == S_IDLE);
	assign acc        = item_valid && item_ready;

	// next state and command decode
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (item_mode)
						MODE_LOAD_OFFS: cmd.wr_offs = 1'b1;
						MODE_LOAD_NBR:  cmd.wr_nbr  = 1'b1;
						MODE_START: begin
							cmd.start_walk = 1'b1;
							state_nxt      = S_RES;
						end
						MODE_STEP: begin
							if (sts.active) begin
								cmd.rd_offs = 1'b1;
								state_nxt   = S_MUL;
							end
						end
						default: state_nxt = S_IDLE;
					endcase
				end
			end
			S_MUL: begin
				cmd.calc  = 1'b1;
				state_nxt = S_NRD;
			end
			S_NRD: begin
				cmd.rd_nbr = 1'b1;
				state_nxt  = S_UPD;
			end
			S_UPD: begin
				cmd.upd   = 1'b1;
				state_nxt = S_RES;
			end
			S_RES: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	`CSRW_ASSERT(a_cmd_onehot, $onehot0(cmd), "more than one datapath command")
	`CSRW_ASSERT_NEXT(a_offs_then_calc, cmd.rd_offs, cmd.calc, "offset read without multiply")
	`CSRW_ASSERT_NEXT(a_nbr_then_upd, cmd.rd_nbr, cmd.upd, "neighbor read without update")

endmodule

`default_nettype wire

/* src/csrw_dp.sv */
// datapath of the random walk block: tables, walker state, result register
// depends on csrw_pkg, csrw_if and csr_graph_random_walk_assert.svh
`default_nettype none
`include "csr_graph_random_walk_assert.svh"

module csrw_dp
	import csrw_pkg::*;
#(
	parameter int MAX_NODES = 1024,
	parameter int MAX_EDGES = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [12:0] table_index,
	input  wire logic [12:0] table_value,
	input  wire logic [9:0]  start_node,
	input  wire logic [15:0] random_fraction,
	input  wire csrw_cmd_t   cmd,
	output csrw_sts_t        sts,
	csrw_cfg_if.sink         cfg,
	csrw_out_if.source       result
);

	localparam int OFFS_AW = $clog2(MAX_NODES + 1);
	localparam int EDGE_AW = $clog2(MAX_EDGES);

	// csr tables
	logic [12:0] offs_mem [0:MAX_NODES];
	logic [9:0]  nbr_mem  [0:MAX_EDGES-1];

	logic [7:0]  walk_len_q;
	logic [9:0]  cur_q;
	logic [7:0]  step_q;
	logic        active_q;
	logic [15:0] frac_q;

	logic [12:0] lo_s1;
	logic [12:0] hi_s1;
	logic        has_row_s1;
	logic [12:0] pick_s2;
	logic        deg_ok_s2;
	logic [12:0] edge_s3;
	logic        ok_s3;
	logic [9:0]  nbr_s3;

	logic [9:0]  pend_node_q;
	logic [12:0] pend_edge_q;
	logic [7:0]  pend_pos_q;

	logic        out_valid_q;
	logic [9:0]  out_node_q;
	logic [12:0] out_edge_q;
	logic [7:0]  out_pos_q;
	logic        out_last_q;

	logic [12:0] deg;
	logic [28:0] prod;
	logic [13:0] edge_sum;
	logic        edge_ok;
	logic [7:0]  step_nxt;
	logic [9:0]  node_nxt;
	logic        last_pend;

	// config register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_len_q <= 8'd8;
		end else if (cfg.valid) begin
			walk_len_q <= cfg.max_steps;
		end
	end

	// table writes
	always_ff @(posedge clk) begin
		if (cmd.wr_offs && (32'(table_index) <= 32'(MAX_NODES))) begin
			offs_mem[OFFS_AW'(table_index)] <= table_value;
		end
		if (cmd.wr_nbr && (32'(table_index) < 32'(MAX_EDGES))) begin
			nbr_mem[EDGE_AW'(table_index)] <= table_value[9:0];
		end
	end

	// row offset reads at current node and the next one
	always_ff @(posedge clk) begin
		if (cmd.rd_offs) begin
			lo_s1      <= offs_mem[OFFS_AW'(cur_q)];
			hi_s1      <= offs_mem[OFFS_AW'(32'(cur_q) + 32'd1)];
			has_row_s1 <= (32'(cur_q) < 32'(MAX_NODES));
			frac_q     <= random_fraction;
		end
	end

	// degree and scaled pick
	assign deg  = hi_s1 - lo_s1;
	assign prod = 29'(frac_q) * 29'(deg);
	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			pick_s2   <= prod[28:16];
			deg_ok_s2 <= has_row_s1 && (hi_s1 > lo_s1);
		end
	end

	// edge index and neighbor read
	assign edge_sum = {1'b0, lo_s1} + {1'b0, pick_s2};
	assign edge_ok  = deg_ok_s2 && (32'(edge_sum) < 32'(MAX_EDGES));
	always_ff @(posedge clk) begin
		if (cmd.rd_nbr) begin
			edge_s3 <= edge_sum[12:0];
			ok_s3   <= edge_ok;
			nbr_s3  <= nbr_mem[EDGE_AW'(edge_sum)];
		end
	end

	assign step_nxt = step_q + 8'd1;
	assign node_nxt = ok_s3 ? nbr_s3 : cur_q;

	// walker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q    <= '0;
			step_q   <= '0;
			active_q <= 1'b0;
		end else if (cmd.start_walk) begin
			cur_q    <= start_node;
			step_q   <= '0;
			active_q <= (walk_len_q != 8'd0);
		end else if (cmd.upd) begin
			cur_q    <= node_nxt;
			step_q   <= step_nxt;
			active_q <= !(step_nxt >= walk_len_q);
		end
	end

	// pending result
	always_ff @(posedge clk) begin
		if (cmd.start_walk) begin
			pend_node_q <= start_node;
			pend_edge_q <= EDGE_NONE;
			pend_pos_q  <= '0;
		end else if (cmd.upd) begin
			pend_node_q <= node_nxt;
			pend_edge_q <= ok_s3 ? edge_s3 : EDGE_NONE;
			pend_pos_q  <= step_nxt;
		end
	end

	assign last_pend = (pend_pos_q >= walk_len_q);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_node_q <= pend_node_q;
			out_edge_q <= pend_edge_q;
			out_pos_q  <= pend_pos_q;
			out_last_q <= last_pend;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.node         = out_node_q;
	assign result.edge_res     = $signed(out_edge_q);
	assign result.position     = out_pos_q;
	assign result.last_of_walk = out_last_q;

	assign sts.active   = active_q;
	assign sts.out_free = !out_valid_q || result.ready;

	`CSRW_ASSERT(a_load_free, !cmd.load_out || sts.out_free, "result overwritten while stalled")
	`CSRW_ASSERT_NEXT(a_last_ends, cmd.load_out && last_pend, !active_q, "walk active after last")
	`CSRW_ASSERT_NEXT(a_move, cmd.upd && ok_s3, cur_q == $past(nbr_s3), "walker did not move")

endmodule

`default_nettype wire

/* src/csr_graph_random_walk.sv */
// Uniform random walk over a graph in compressed-sparse-row form.
// Channels: item (requests), result (walk positions), cfg (walk length).
// A request is taken when valid and ready are high at a clock edge.
// Mode 0 writes a row offset, mode 1 writes a neighbor id; both are written
// as they are taken and give no result. Mode 2 starts a walk and returns the
// start node at position 0 through the pending result and output registers.
// Mode 3 takes one step: offset read, 16x13 multiply, neighbor read, update
// and result load follow in that order; a step with no active walk is dropped.
// The block works on one request at a time: it takes no new request until
// the last one is through. Results wait in an output register; while the
// receiver stalls, the next request is still taken and worked on until its
// result needs that register. Reset clears the walker (node 0, no active
// walk) and sets walk length to 8; the offset and neighbor tables hold no
// defined value until written. The user must write the walk length register
// only while the block is idle; the block itself does not enforce it.
// depends on csrw_pkg, csrw_if, csrw_ctrl and csrw_dp
`default_nettype none

module csr_graph_random_walk
	import csrw_pkg::*;
#(
	parameter int MAX_NODES = 1024,
	parameter int MAX_EDGES = 4096
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	csrw_in_if.sink    item,
	csrw_out_if.source result,
	csrw_cfg_if.sink   cfg
);

	csrw_cmd_t cmd;
	csrw_sts_t sts;
	logic      item_ready;

	assign item.ready = item_ready;

	// sequencing of each request
	csrw_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_mode  (item.mode),
		.item_ready (item_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// tables, walker and result register
	csrw_dp #(
		.MAX_NODES (MAX_NODES),
		.MAX_EDGES (MAX_EDGES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.table_index     (item.table_index),
		.table_value     (item.table_value),
		.start_node      (item.start_node),
		.random_fraction (item.random_fraction),
		.cmd             (cmd),
		.sts             (sts),
		.cfg             (cfg),
		.result          (result)
	);

endmodule

`default_nettype wire

/* bench/tb_csr_graph_random_walk.sv */
`timescale 1ns / 100ps
// testbench for csr_graph_random_walk: table loads, walk starts and steps
// checked against an in-bench walker model, with random stalls on both sides
// depends on csrw_pkg, csrw_if and the csr_graph_random_walk rtl

module tb_csr_graph_random_walk;
	import csrw_pkg::*;

	localparam int N_NODES = 1024;
	localparam int N_EDGES = 4096;

	// one expected walk position
	typedef struct {
		logic [9:0]         node;
		logic signed [12:0] edge_res;
		logic [7:0]         position;
		logic               last;
	} walk_pos_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	csrw_in_if  item_if ();
	csrw_out_if res_if ();
	csrw_cfg_if cfg_if ();

	csr_graph_random_walk i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if),
		.result (res_if),
		.cfg    (cfg_if)
	);

	// clock
	always #5 clk = ~clk;

	// walker model state
	logic [12:0] row_offs [0:N_NODES];
	bit          offs_set [0:N_NODES];
	logic [9:0]  nbr_ids [0:N_EDGES-1];
	bit          nbr_set [0:N_EDGES-1];
	logic [9:0]  walker_node = '0;
	logic [7:0]  walker_steps = '0;
	bit          walker_on = 1'b0;
	logic [7:0]  walk_len = 8'd8;

	walk_pos_t pending_positions[$];
	int mismatches = 0;
	int useful_items = 0;
	int tx_idle_pct = 20;
	int rx_idle_pct = 20;
	int rx_hold = 0;

	// random gap: mostly none or short, a few long
	function automatic int pick_gap(input int pct);
		if (pct == 0 || $urandom_range(0, 99) >= pct)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(12, 40);
		return $urandom_range(1, 3);
	endfunction

	// queue one walk position, a final one ends the walk
	function automatic void push_position(input logic [9:0] n, input logic [12:0] e,
		input logic [7:0] p);
		walk_pos_t w;
		w.node = n;
		w.edge_res = e;
		w.position = p;
		w.last = (p >= walk_len);
		pending_positions.push_back(w);
		if (w.last)
			walker_on = 1'b0;
	endfunction

	// apply one accepted request to the walker model
	function automatic void advance_walker(input logic [1:0] mode, input logic [12:0] idx,
		input logic [12:0] val, input logic [9:0] start, input logic [15:0] frac);
		int unsigned lo, hi, e, nxt;
		logic [12:0] edge_id;
		case (mode)
			MODE_LOAD_OFFS: begin
				if (idx <= N_NODES) begin
					row_offs[idx] = val;
					offs_set[idx] = 1'b1;
					useful_items++;
				end
			end
			MODE_LOAD_NBR: begin
				if (idx < N_EDGES) begin
					nbr_ids[idx] = val[9:0];
					nbr_set[idx] = 1'b1;
					useful_items++;
				end
			end
			MODE_START: begin
				walker_node = start;
				walker_steps = '0;
				walker_on = 1'b1;
				useful_items++;
				push_position(walker_node, EDGE_NONE, 8'd0);
			end
			default: begin
				if (walker_on) begin
					useful_items++;
					edge_id = EDGE_NONE;
					nxt = int'(walker_node) + 1;
					if (nxt <= N_NODES) begin
						lo = 32'(row_offs[walker_node]);
						hi = 32'(row_offs[nxt]);
						if (hi > lo) begin
							e = lo + ((int'(frac) * (hi - lo)) >> 16);
							if (e < N_EDGES) begin
								edge_id = e[12:0];
								walker_node = nbr_ids[e];
							end
						end
					end
					walker_steps = walker_steps + 8'd1;
					push_position(walker_node, edge_id, walker_steps);
				end
			end
		endcase
	endfunction

	// offset for an unwritten row, kept near its neighbors so degrees stay small
	function automatic logic [12:0] fill_offset(input int k);
		if (k > 0 && offs_set[k-1])
			return row_offs[k-1] + (($urandom_range(0, 7) == 0) ? 13'd0 :
				13'($urandom_range(1, 4)));
		if (k < N_NODES && offs_set[k+1])
			return row_offs[k+1] - 13'($urandom_range(1, 4));
		return 13'($urandom_range(0, 4095));
	endfunction

	// neighbor id, mostly among a few hot nodes, sometimes with high bits set
	function automatic logic [12:0] fill_node();
		if ($urandom_range(0, 9) == 0)
			return 13'($urandom_range(0, 8191));
		if ($urandom_range(0, 4) == 0)
			return 13'($urandom_range(0, 1023));
		return 13'($urandom_range(0, 15));
	endfunction

	// send one request; fields the mode does not use get random values
	task automatic send_req(input logic [1:0] mode, input logic [12:0] idx,
		input logic [12:0] val, input logic [9:0] start, input logic [15:0] frac);
		int gap;
		if (mode != MODE_LOAD_OFFS && mode != MODE_LOAD_NBR) begin
			idx = 13'($urandom_range(0, 8191));
			val = 13'($urandom_range(0, 8191));
		end
		if (mode != MODE_START)
			start = 10'($urandom_range(0, 1023));
		if (mode != MODE_STEP)
			frac = 16'($urandom_range(0, 65535));
		gap = pick_gap(tx_idle_pct);
		@(negedge clk);
		if (gap > 0) begin
			item_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_if.valid = 1'b1;
		item_if.mode = mode;
		item_if.table_index = idx;
		item_if.table_value = val;
		item_if.start_node = start;
		item_if.random_fraction = frac;
		@(posedge clk);
		while (!item_if.ready)
			@(posedge clk);
		advance_walker(mode, idx, val, start, frac);
	endtask

	// step request, preceded by loads for any table entry it would read unwritten
	task automatic take_step(input logic [15:0] frac);
		int n;
		int unsigned lo, hi, e;
		if (walker_on) begin
			n = int'(walker_node);
			if (!offs_set[n])
				send_req(MODE_LOAD_OFFS, 13'(n), fill_offset(n), '0, '0);
			if (!offs_set[n+1])
				send_req(MODE_LOAD_OFFS, 13'(n + 1), fill_offset(n + 1), '0, '0);
			lo = 32'(row_offs[n]);
			hi = 32'(row_offs[n+1]);
			if (hi > lo) begin
				e = lo + ((int'(frac) * (hi - lo)) >> 16);
				if (e < N_EDGES && !nbr_set[e])
					send_req(MODE_LOAD_NBR, 13'(e), fill_node(), '0, '0);
			end
		end
		send_req(MODE_STEP, '0, '0, '0, frac);
	endtask

	// stop sending and wait for every outstanding position
	task automatic wait_idle();
		@(negedge clk);
		item_if.valid = 1'b0;
		while (pending_positions.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// walk length register write, only with the block idle
	task automatic write_walk_len(input logic [7:0] len);
		wait_idle();
		@(negedge clk);
		cfg_if.valid = 1'b1;
		cfg_if.max_steps = len;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		walk_len = len;
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	// table edge cases, ignored loads and every kind of stay
	task automatic test_table_cases();
		send_req(MODE_LOAD_OFFS, 13'd0, 13'd0, '0, '0);
		send_req(MODE_LOAD_OFFS, 13'd1, 13'd3, '0, '0);
		send_req(MODE_LOAD_OFFS, 13'd2, 13'd3, '0, '0);
		send_req(MODE_LOAD_OFFS, 13'd3, 13'd2, '0, '0);
		send_req(MODE_LOAD_NBR, 13'd0, 13'd1, '0, '0);
		// only the low node bits are kept
		send_req(MODE_LOAD_NBR, 13'd1, 13'h1C02, '0, '0);
		send_req(MODE_LOAD_NBR, 13'd2, 13'd1023, '0, '0);
		send_req(MODE_LOAD_OFFS, 13'd1023, 13'd4095, '0, '0);
		send_req(MODE_LOAD_OFFS, 13'd1024, 13'd8191, '0, '0);
		send_req(MODE_LOAD_NBR, 13'd4095, 13'd0, '0, '0);
		// out of range loads are dropped
		send_req(MODE_LOAD_OFFS, 13'd1025, 13'd8191, '0, '0);
		send_req(MODE_LOAD_OFFS, 13'd8191, 13'd8191, '0, '0);
		send_req(MODE_LOAD_NBR, 13'd4096, 13'd8191, '0, '0);
		send_req(MODE_LOAD_NBR, 13'd8191, 13'd8191, '0, '0);
		// step with no walk running
		send_req(MODE_STEP, '0, '0, '0, 16'hFFFF);
		send_req(MODE_START, '0, '0, 10'd0, '0);
		send_req(MODE_STEP, '0, '0, '0, 16'h0000);
		// node without neighbors
		send_req(MODE_STEP, '0, '0, '0, 16'h8000);
		send_req(MODE_START, '0, '0, 10'd1023, '0);
		// chosen edge past the end of the neighbor table
		send_req(MODE_STEP, '0, '0, '0, 16'hFFFF);
		send_req(MODE_STEP, '0, '0, '0, 16'h0000);
		send_req(MODE_STEP, '0, '0, '0, 16'hFFFF);
		// decreasing offsets
		send_req(MODE_START, '0, '0, 10'd2, '0);
		send_req(MODE_STEP, '0, '0, '0, 16'h1234);
		wait_idle();
	endtask

	// walk length zero, one, lowered mid walk and the maximum
	task automatic test_walk_length();
		int i;
		write_walk_len(8'd0);
		send_req(MODE_START, '0, '0, 10'd5, '0);
		take_step(16'h4000);
		write_walk_len(8'd1);
		send_req(MODE_START, '0, '0, 10'd0, '0);
		take_step(16'h0000);
		take_step(16'h0000);
		write_walk_len(8'd20);
		send_req(MODE_START, '0, '0, 10'd0, '0);
		for (i = 0; i < 4; i++)
			take_step(16'($urandom_range(0, 65535)));
		write_walk_len(8'd2);
		take_step(16'($urandom_range(0, 65535)));
		take_step(16'($urandom_range(0, 65535)));
		// full length walk with no idling
		write_walk_len(8'd255);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		send_req(MODE_START, '0, '0, 10'd3, '0);
		for (i = 0; i < 256; i++)
			take_step(16'($urandom_range(0, 65535)));
		wait_idle();
		tx_idle_pct = 20;
		rx_idle_pct = 20;
	endtask

	// long receiver hold while requests keep coming, then a full drain
	task automatic test_backpressure();
		int i;
		write_walk_len(8'd200);
		tx_idle_pct = 0;
		send_req(MODE_START, '0, '0, 10'd4, '0);
		rx_hold = 150;
		for (i = 0; i < 40; i++)
			take_step(16'($urandom_range(0, 65535)));
		wait_idle();
		tx_idle_pct = 30;
		rx_idle_pct = 30;
		for (i = 0; i < 20; i++)
			take_step(16'($urandom_range(0, 65535)));
		wait_idle();
	endtask

	// random walks with random content, plus stray loads and steps
	task automatic test_random_walks(input int target);
		int i, n_steps, sel;
		logic [9:0] start;
		while (useful_items < target) begin
			if ($urandom_range(0, 9) == 0) begin
				sel = $urandom_range(0, 19);
				if (sel == 0)
					write_walk_len(8'd0);
				else if (sel == 1)
					write_walk_len(8'd255);
				else if (sel == 2)
					write_walk_len(8'd1);
				else
					write_walk_len(8'($urandom_range(2, 24)));
			end
			case ($urandom_range(0, 3))
				0: tx_idle_pct = 0;
				1: tx_idle_pct = 10;
				2: tx_idle_pct = 30;
				default: tx_idle_pct = 60;
			endcase
			case ($urandom_range(0, 3))
				0: rx_idle_pct = 0;
				1: rx_idle_pct = 10;
				2: rx_idle_pct = 30;
				default: rx_idle_pct = 60;
			endcase
			sel = $urandom_range(0, 9);
			if (sel < 8) begin
				start = ($urandom_range(0, 4) == 0) ? 10'($urandom_range(0, 1023)) :
					10'($urandom_range(0, 15));
				send_req(MODE_START, '0, '0, start, '0);
				n_steps = int'(walk_len) + $urandom_range(0, 2);
				for (i = 0; i < n_steps; i++)
					take_step(16'($urandom_range(0, 65535)));
			end else if (sel == 8) begin
				// stray loads anywhere in the index space
				send_req(MODE_LOAD_OFFS, 13'($urandom_range(0, 8191)),
					13'($urandom_range(0, 8191)), '0, '0);
				send_req(MODE_LOAD_NBR, 13'($urandom_range(0, 8191)),
					13'($urandom_range(0, 8191)), '0, '0);
			end else begin
				take_step(16'($urandom_range(0, 65535)));
			end
		end
		wait_idle();
	endtask

	function automatic void report(input string field, input logic signed [31:0] want,
		input logic signed [31:0] got);
		mismatches++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
	endfunction

	// compare each accepted result with the oldest expected position
	always @(posedge clk) begin
		walk_pos_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_positions.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, actual node %0d pos %0d",
					$time, res_if.node, res_if.position);
			end else begin
				want = pending_positions.pop_front();
				if (res_if.node !== want.node)
					report("node", 32'(want.node), 32'(res_if.node));
				if (res_if.edge_res !== want.edge_res)
					report("edge_res", 32'(want.edge_res), 32'(res_if.edge_res));
				if (res_if.position !== want.position)
					report("position", 32'(want.position), 32'(res_if.position));
				if (res_if.last_of_walk !== want.last)
					report("last_of_walk", 32'(want.last), 32'(res_if.last_of_walk));
			end
		end
	end

	// result side ready with random stalls and requested holds
	initial begin
		int stall_left;
		stall_left = 0;
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				res_if.ready = 1'b0;
				rx_hold--;
			end else begin
				if (stall_left == 0)
					stall_left = pick_gap(rx_idle_pct);
				if (stall_left > 0) begin
					res_if.ready = 1'b0;
					stall_left--;
				end else begin
					res_if.ready = 1'b1;
				end
			end
		end
	end

	// main sequence
	initial begin
		item_if.valid = 1'b0;
		item_if.mode = MODE_LOAD_OFFS;
		item_if.table_index = '0;
		item_if.table_value = '0;
		item_if.start_node = '0;
		item_if.random_fraction = '0;
		cfg_if.valid = 1'b0;
		cfg_if.max_steps = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_table_cases();
		test_walk_length();
		test_backpressure();
		test_random_walks(1200);
		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_positions.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// run time limit
	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+src
src/csrw_pkg.sv
src/csrw_if.sv
src/csrw_ctrl.sv
src/csrw_dp.sv
src/csr_graph_random_walk.sv
bench/tb_csr_graph_random_walk.sv
